@@ design/asmc_pkg.sv @@
// ----------------------------------------------------------------------------
// asmc_pkg: shared types and constants for the converter scan to MIDI block
// Field widths, message and channel codes, scaling constants and stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package asmc_pkg;

    localparam int RAW_W      = 16;
    localparam int CC_W       = 7;
    localparam int BEND_W     = 14;
    localparam int CHIP_W     = 2;
    localparam int SLOT_W     = 2;
    localparam int CH_W       = 4;
    localparam int KIND_W     = 2;
    localparam int WORD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 16;
    localparam int WIN_W      = 14;

    localparam int NUM_CHIPS  = 3;
    localparam int NUM_CC_CH  = 8;
    localparam int CC_IDX_W   = 3;

    // Scaling: x * K / FULL_SCALE as ((x * K) >> FS_TZ) * RECIP >> RECIP_SHIFT
    localparam int FULL_SCALE  = 26400;
    localparam int FS_TZ       = 5;
    localparam int FS_ODD      = FULL_SCALE >> FS_TZ;
    localparam int RECIP_SHIFT = 35;
    localparam int RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FS_ODD) - 64'd1) / 64'(FS_ODD));

    localparam int BP_W = RAW_W + BEND_W;
    localparam int CP_W = RAW_W + CC_W;
    localparam int BM_W = BP_W - FS_TZ + RECIP_W;
    localparam int CM_W = CP_W - FS_TZ + RECIP_W;
    localparam int BQ_W = BM_W - RECIP_SHIFT;
    localparam int CQ_W = CM_W - RECIP_SHIFT;

    localparam int WIN_SW = RAW_W + 2;
    localparam int BND_SW = BEND_W + 2;

    localparam int CENTER_RAW = FULL_SCALE / 2;
    localparam logic [BEND_W-1:0] BEND_CENTER = BEND_W'(8192);
    localparam logic [BEND_W-1:0] BEND_MAX    = BEND_W'(16383);
    localparam logic [CC_W-1:0]   CC_MAX      = CC_W'(127);

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BEND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POT_THR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JOY_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_WIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEND_STEP  = 2'd3;

    localparam logic [CHIP_W-1:0] CHIP_POTS  = 2'd0;
    localparam logic [CHIP_W-1:0] CHIP_MIXED = 2'd1;
    localparam logic [CHIP_W-1:0] CHIP_JOY   = 2'd2;

    localparam logic [CH_W-1:0] CH_MIX_BASE = 4'd4;
    localparam logic [CH_W-1:0] CH_LAST_POT = 4'd5;
    localparam logic [CH_W-1:0] CH_SLIDER   = 4'd6;
    localparam logic [CH_W-1:0] CH_JOY_Y    = 4'd7;
    localparam logic [CH_W-1:0] CH_JOY_X    = 4'd8;
    localparam logic [CH_W-1:0] CH_NONE     = 4'd15;

    localparam logic [CC_W-1:0] CC_POT_BASE = 7'd20;
    localparam logic [CC_W-1:0] CC_SLIDER   = 7'd26;
    localparam logic [CC_W-1:0] CC_MOD      = 7'd1;

    localparam logic [WORD_W-1:0] CFG_BASE = 16'h8000;
    localparam logic [2:0]        CFG_PGA  = 3'h1;
    localparam logic [2:0]        CFG_RATE = 3'h7;

    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic              ok;
        logic [CH_W-1:0]   ch;
        logic [CHIP_W-1:0] chip;
        logic [SLOT_W-1:0] slot_next;
        logic [CHIP_W-1:0] next_chip;
    } scan_t;

    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic              ok;
        logic [CH_W-1:0]   ch;
        logic [CHIP_W-1:0] chip;
        logic [SLOT_W-1:0] slot_next;
        logic [CHIP_W-1:0] next_chip;
        logic [CC_W-1:0]   cc_q;
        logic [BEND_W-1:0] bend_q;
        logic              in_window;
    } scaled_t;

    typedef struct packed {
        logic [KIND_W-1:0] msg_kind;
        logic [CC_W-1:0]   cc_number;
        logic [CC_W-1:0]   cc_value;
        logic [BEND_W-1:0] bend_value;
        logic [CHIP_W-1:0] cfg_chip;
        logic [SLOT_W-1:0] cfg_mux;
        logic [WORD_W-1:0] cfg_word;
        logic [CHIP_W-1:0] next_chip;
    } result_t;

    function automatic logic [CH_W-1:0] channel_of(
        input logic [CHIP_W-1:0] chip,
        input logic [SLOT_W-1:0] slot
    );
        logic [CH_W-1:0] ch;
        case (chip)
            CHIP_POTS:  ch = CH_W'(slot);
            CHIP_MIXED: ch = CH_MIX_BASE + CH_W'(slot);
            default:    ch = (slot == '0) ? CH_JOY_X : CH_NONE;
        endcase
        return ch;
    endfunction

    function automatic logic [WORD_W-1:0] cfg_word_of(input logic [SLOT_W-1:0] slot);
        return CFG_BASE | {2'b01, slot, 12'd0} | (WORD_W'(CFG_PGA) << 9)
               | (WORD_W'(CFG_RATE) << 5);
    endfunction

endpackage

`default_nettype wire

@@ design/asmc_scan_if.sv @@
// ----------------------------------------------------------------------------
// asmc_scan_if: conversion input channel
// Valid/ready channel carrying one conversion result and its read status.
// ----------------------------------------------------------------------------
`default_nettype none

interface asmc_scan_if import asmc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw;
    logic             read_ok;

    modport source (output valid, raw, read_ok, input ready);
    modport sink   (input valid, raw, read_ok, output ready);
endinterface

`default_nettype wire

@@ design/asmc_midi_if.sv @@
// ----------------------------------------------------------------------------
// asmc_midi_if: message output channel
// Valid/ready channel carrying one message and the converter configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface asmc_midi_if import asmc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] msg_kind;
    logic [CC_W-1:0]   cc_number;
    logic [CC_W-1:0]   cc_value;
    logic [BEND_W-1:0] bend_value;
    logic [CHIP_W-1:0] cfg_chip;
    logic [SLOT_W-1:0] cfg_mux;
    logic [WORD_W-1:0] cfg_word;
    logic [CHIP_W-1:0] next_chip;

    modport source (output valid, msg_kind, cc_number, cc_value, bend_value, cfg_chip,
                    cfg_mux, cfg_word, next_chip, input ready);
    modport sink   (input valid, msg_kind, cc_number, cc_value, bend_value, cfg_chip,
                    cfg_mux, cfg_word, next_chip, output ready);
endinterface

`default_nettype wire

@@ design/adc_scan_to_midi_control.sv @@
// ----------------------------------------------------------------------------
// adc_scan_to_midi_control: converter scan to MIDI control messages
// Pipeline: an accepted transaction moves through the scan, scale and result registers
// in order. Throughput: one transaction per cycle while midi_out.ready holds; the scan,
// scale and result registers each hold one transaction and advance independently.
// Reset: thresholds, window and step take their defaults, scan starts at chip 0,
// all mux slots and last sent levels clear, bend level returns to centre.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_scan_to_midi_control
    import asmc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    asmc_scan_if.sink                  scan_in,
    asmc_midi_if.source                midi_out
);

    logic [THR_W-1:0]  pot_thr_reg;
    logic [THR_W-1:0]  joy_thr_reg;
    logic [WIN_W-1:0]  center_win_reg;
    logic [BEND_W-1:0] bend_step_reg;

    logic [CHIP_W-1:0] scan_chip_reg;
    logic [SLOT_W-1:0] mux_slot_reg [NUM_CHIPS];
    logic [RAW_W-1:0]  last_level_reg [NUM_CC_CH];
    logic [BEND_W-1:0] bend_level_reg;

    logic    s0_valid_reg, s1_valid_reg, s2_valid_reg;
    scan_t   s0_reg, s0_next;
    scaled_t s1_reg, s1_next;
    result_t s2_reg, s2_next;

    logic s2_free, s1_move, s1_free, s0_move, in_take;

    assign s2_free = !s2_valid_reg || midi_out.ready;
    assign s1_move = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s1_move;
    assign s0_move = s0_valid_reg && s1_free;
    assign scan_in.ready = !s0_valid_reg || s0_move;
    assign in_take = scan_in.valid && scan_in.ready;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pot_thr_reg    <= THR_W'(64);
            joy_thr_reg    <= THR_W'(128);
            center_win_reg <= WIN_W'(300);
            bend_step_reg  <= BEND_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POT_THR:    pot_thr_reg    <= cfg_data[THR_W-1:0];
                REG_JOY_THR:    joy_thr_reg    <= cfg_data[THR_W-1:0];
                REG_CENTER_WIN: center_win_reg <= cfg_data[WIN_W-1:0];
                REG_BEND_STEP:  bend_step_reg  <= cfg_data[BEND_W-1:0];
                default:        ;
            endcase
        end
    end

    // Scan stage: pick the channel and advance chip and mux
    logic [SLOT_W-1:0] cur_slot;
    logic [CHIP_W-1:0] chip_after;

    always_comb
    begin
        cur_slot   = mux_slot_reg[scan_chip_reg];
        chip_after = (scan_chip_reg == CHIP_JOY) ? CHIP_POTS : scan_chip_reg + 1'b1;
        s0_next.raw       = scan_in.raw;
        s0_next.ok        = scan_in.read_ok;
        s0_next.ch        = channel_of(scan_chip_reg, cur_slot);
        s0_next.chip      = scan_chip_reg;
        s0_next.slot_next = cur_slot + 1'b1;
        s0_next.next_chip = chip_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_chip_reg <= CHIP_POTS;
            for (int i = 0; i < NUM_CHIPS; i++)
            begin
                mux_slot_reg[i] <= '0;
            end
        end
        else if (in_take)
        begin
            scan_chip_reg               <= chip_after;
            mux_slot_reg[scan_chip_reg] <= s0_next.slot_next;
        end
    end

    // Scale stage
    logic [BP_W-1:0]          bend_prod;
    logic [CP_W-1:0]          cc_prod;
    logic [BM_W-1:0]          bend_mul;
    logic [CM_W-1:0]          cc_mul;
    logic [BQ_W-1:0]          bend_quo;
    logic [CQ_W-1:0]          cc_quo;
    logic signed [WIN_SW-1:0] raw_s, win_lo, win_hi;

    always_comb
    begin
        bend_prod = {s0_reg.raw, BEND_W'(0)} - BP_W'(s0_reg.raw);
        cc_prod   = {s0_reg.raw, CC_W'(0)} - CP_W'(s0_reg.raw);
        bend_mul  = BM_W'(bend_prod[BP_W-1:FS_TZ]) * BM_W'(RECIP);
        cc_mul    = CM_W'(cc_prod[CP_W-1:FS_TZ]) * CM_W'(RECIP);
        bend_quo  = bend_mul[BM_W-1:RECIP_SHIFT];
        cc_quo    = cc_mul[CM_W-1:RECIP_SHIFT];
        raw_s     = $signed(WIN_SW'(s0_reg.raw));
        win_lo    = $signed(WIN_SW'(CENTER_RAW)) - $signed(WIN_SW'(center_win_reg));
        win_hi    = $signed(WIN_SW'(CENTER_RAW)) + $signed(WIN_SW'(center_win_reg));

        s1_next.raw       = s0_reg.raw;
        s1_next.ok        = s0_reg.ok;
        s1_next.ch        = s0_reg.ch;
        s1_next.chip      = s0_reg.chip;
        s1_next.slot_next = s0_reg.slot_next;
        s1_next.next_chip = s0_reg.next_chip;
        s1_next.cc_q      = (cc_quo > CQ_W'(CC_MAX)) ? CC_MAX : cc_quo[CC_W-1:0];
        s1_next.bend_q    = (bend_quo > BQ_W'(BEND_MAX)) ? BEND_MAX : bend_quo[BEND_W-1:0];
        s1_next.in_window = (raw_s >= win_lo) && (raw_s <= win_hi);
    end

    // Decide stage: hysteresis, deadband and message build
    logic [RAW_W-1:0]         last_lvl, diff, thr;
    logic                     cc_send, bend_send, dead;
    logic [BEND_W-1:0]        bend_val;
    logic signed [BND_SW-1:0] b_s, dead_lo, dead_hi;
    logic [CC_W-1:0]          cc_num;

    always_comb
    begin
        last_lvl = last_level_reg[s1_reg.ch[CC_IDX_W-1:0]];
        diff     = (s1_reg.raw > last_lvl) ? s1_reg.raw - last_lvl : last_lvl - s1_reg.raw;
        thr      = (s1_reg.ch == CH_JOY_Y) ? joy_thr_reg : pot_thr_reg;
        cc_send  = s1_reg.ok && !s1_reg.ch[CH_W-1] && (diff >= thr);

        if (s1_reg.ch <= CH_LAST_POT)
            cc_num = CC_POT_BASE + CC_W'(s1_reg.ch);
        else if (s1_reg.ch == CH_SLIDER)
            cc_num = CC_SLIDER;
        else
            cc_num = CC_MOD;

        bend_val  = s1_reg.in_window ? BEND_CENTER : s1_reg.bend_q;
        b_s       = $signed(BND_SW'(bend_val));
        dead_lo   = $signed(BND_SW'(bend_level_reg)) - $signed(BND_SW'(bend_step_reg));
        dead_hi   = $signed(BND_SW'(bend_level_reg)) + $signed(BND_SW'(bend_step_reg));
        dead      = (bend_val != BEND_CENTER) && (b_s > dead_lo) && (b_s < dead_hi);
        bend_send = s1_reg.ok && (s1_reg.ch == CH_JOY_X) && !dead
                    && (bend_val != bend_level_reg);

        s2_next            = '0;
        s2_next.cfg_chip   = s1_reg.chip;
        s2_next.cfg_mux    = s1_reg.slot_next;
        s2_next.cfg_word   = cfg_word_of(s1_reg.slot_next);
        s2_next.next_chip  = s1_reg.next_chip;
        if (bend_send)
        begin
            s2_next.msg_kind   = KIND_BEND;
            s2_next.bend_value = bend_val;
        end
        else if (cc_send)
        begin
            s2_next.msg_kind  = KIND_CC;
            s2_next.cc_number = cc_num;
            s2_next.cc_value  = s1_reg.cc_q;
        end
        else
        begin
            s2_next.msg_kind = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bend_level_reg <= BEND_CENTER;
            for (int i = 0; i < NUM_CC_CH; i++)
            begin
                last_level_reg[i] <= '0;
            end
        end
        else if (s1_move)
        begin
            if (cc_send)
                last_level_reg[s1_reg.ch[CC_IDX_W-1:0]] <= s1_reg.raw;
            if (bend_send)
                bend_level_reg <= bend_val;
        end
    end

    // Pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan_in.ready)
                s0_valid_reg <= scan_in.valid;
            if (s1_free)
                s1_valid_reg <= s0_valid_reg;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s0_reg <= s0_next;
        if (s0_move)
            s1_reg <= s1_next;
        if (s1_move)
            s2_reg <= s2_next;
    end

    assign midi_out.valid      = s2_valid_reg;
    assign midi_out.msg_kind   = s2_reg.msg_kind;
    assign midi_out.cc_number  = s2_reg.cc_number;
    assign midi_out.cc_value   = s2_reg.cc_value;
    assign midi_out.bend_value = s2_reg.bend_value;
    assign midi_out.cfg_chip   = s2_reg.cfg_chip;
    assign midi_out.cfg_mux    = s2_reg.cfg_mux;
    assign midi_out.cfg_word   = s2_reg.cfg_word;
    assign midi_out.next_chip  = s2_reg.next_chip;

    a_chip_rotates: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> scan_chip_reg == (($past(scan_chip_reg) == CHIP_JOY) ? CHIP_POTS
                                      : $past(scan_chip_reg) + 1'b1))
        else $error("scan chip did not advance round robin");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("scale stage changed while stalled");

    a_bend_from_joy: assert property (@(posedge clk) disable iff (!rst_n)
        (midi_out.valid && midi_out.msg_kind == KIND_BEND) |-> midi_out.cfg_chip == CHIP_JOY)
        else $error("pitch bend from a chip without the joystick");

    a_cc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (midi_out.valid && midi_out.msg_kind == KIND_CC) |-> midi_out.bend_value == '0)
        else $error("bend value set on a control change");

    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (midi_out.valid && midi_out.msg_kind == KIND_NONE)
            |-> (midi_out.cc_number == '0 && midi_out.cc_value == '0
                 && midi_out.bend_value == '0))
        else $error("payload set on an empty message");

endmodule

`default_nettype wire
